// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== design/ccfp_pkg.sv =====
package ccfp_pkg;

    localparam int HDR_BYTES   = 18;
    localparam int IDX_W       = 5;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 104;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [15:0] MAGIC_RST = 16'hABCD;
    localparam logic [7:0]  MAXV_RST  = 8'd2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_TRUNCATED   = 3'd4,
        ST_CRC_BAD     = 3'd5
    } t_status;

    typedef enum logic {
        CFG_MAGIC_WORD  = 1'b0,
        CFG_MAX_VERSION = 1'b1
    } t_cfg_index;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef struct packed {
        logic                  last;
        t_kind                 kind;
        logic [OUT_DATA_W-1:0] data;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== design/crc_checked_frame_parser.sv =====
// Channel   Dir  Beat content (lowest bit first)
// s_axis    in   tdata: data_byte[7:0]; tlast: end_of_buffer
// m_axis    out  tdata: payload_byte, status, message_type, sequence_number,
//                flag_bits, payload_length, zero pad; tuser: kind; tlast: last_of_run
// cfg       in   i_cfg_we, i_cfg_index (0 magic_word, 1 max_version), i_cfg_data
//
// Header, CRC and status are updated in the cycle an input beat is taken.
// An input beat makes up to two result beats, written into a four-entry output queue.
// Input is ready while the queue has at least two free entries, so one beat per cycle is
// sustained while each beat makes one result beat and the output side drains one per cycle.
// Reset is synchronous and active low; it clears the parser state and the queue.
`include "assert_macros.svh"

module crc_checked_frame_parser
    import ccfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic                  s_axis_tlast,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // payload_byte[7:0], status[10:8],
                                                  // message_type[26:11],
                                                  // sequence_number[58:27],
                                                  // flag_bits[66:59],
                                                  // payload_length[98:67], pad[103:99]
    output logic                  m_axis_tuser,   // kind
    output logic                  m_axis_tlast,

    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    logic [15:0]        r_magic_word;
    logic [7:0]         r_max_version;

    logic [IDX_W-1:0]   r_hdr_idx,  n_hdr_idx;
    logic [15:0]        r_magic,    n_magic;
    logic [7:0]         r_version,  n_version;
    logic [7:0]         r_flags,    n_flags;
    logic [15:0]        r_type,     n_type;
    logic [31:0]        r_length,   n_length;
    logic [31:0]        r_sequence, n_sequence;
    logic [31:0]        r_checksum, n_checksum;
    logic [31:0]        r_crc,      n_crc;
    logic [31:0]        r_pay_cnt,  n_pay_cnt;

    logic [IDX_W-1:0]   upd_hdr_idx;
    logic [15:0]        upd_magic;
    logic [7:0]         upd_version;
    logic [7:0]         upd_flags;
    logic [15:0]        upd_type;
    logic [31:0]        upd_length;
    logic [31:0]        upd_sequence;
    logic [31:0]        upd_checksum;
    logic [31:0]        upd_crc;
    logic [31:0]        upd_pay_cnt;

    t_result            r_queue [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic               in_fire;
    logic               out_fire;
    logic               hdr_active;
    logic               pay_take;
    logic               push_pay;
    logic               push_st;
    t_status            status;
    t_result            pay_entry;
    t_result            st_entry;
    logic [7:0]         b;

    assign b          = s_axis_tdata;
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_fire   = m_axis_tvalid && m_axis_tready;
    assign hdr_active = r_hdr_idx < IDX_W'(HDR_BYTES);
    assign pay_take   = !hdr_active && (r_pay_cnt < r_length);
    assign push_pay   = in_fire && pay_take;
    assign push_st    = in_fire && s_axis_tlast;

    always_comb begin
        upd_hdr_idx  = r_hdr_idx;
        upd_magic    = r_magic;
        upd_version  = r_version;
        upd_flags    = r_flags;
        upd_type     = r_type;
        upd_length   = r_length;
        upd_sequence = r_sequence;
        upd_checksum = r_checksum;
        upd_crc      = r_crc;
        upd_pay_cnt  = r_pay_cnt;
        if (hdr_active) begin
            upd_hdr_idx = r_hdr_idx + IDX_W'(1);
            case (r_hdr_idx)
                5'd0:  upd_magic[15:8]        = b;
                5'd1:  upd_magic[7:0]         = b;
                5'd2:  upd_version            = b;
                5'd3:  upd_flags              = b;
                5'd4:  upd_type[15:8]         = b;
                5'd5:  upd_type[7:0]          = b;
                5'd6:  upd_length[31:24]      = b;
                5'd7:  upd_length[23:16]      = b;
                5'd8:  upd_length[15:8]       = b;
                5'd9:  upd_length[7:0]        = b;
                5'd10: upd_sequence[31:24]    = b;
                5'd11: upd_sequence[23:16]    = b;
                5'd12: upd_sequence[15:8]     = b;
                5'd13: upd_sequence[7:0]      = b;
                5'd14: upd_checksum[31:24]    = b;
                5'd15: upd_checksum[23:16]    = b;
                5'd16: upd_checksum[15:8]     = b;
                5'd17: upd_checksum[7:0]      = b;
                default: upd_hdr_idx = r_hdr_idx;
            endcase
        end else if (pay_take) begin
            upd_crc     = crc_byte(r_crc, b);
            upd_pay_cnt = r_pay_cnt + 32'd1;
        end
    end

    always_comb begin
        if (upd_hdr_idx < IDX_W'(HDR_BYTES)) begin
            status = ST_TOO_SHORT;
        end else if (upd_magic != r_magic_word) begin
            status = ST_BAD_MAGIC;
        end else if (upd_version > r_max_version) begin
            status = ST_BAD_VERSION;
        end else if (upd_pay_cnt < upd_length) begin
            status = ST_TRUNCATED;
        end else if ((upd_crc ^ CRC_INIT) != upd_checksum) begin
            status = ST_CRC_BAD;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        pay_entry.last = !s_axis_tlast;
        pay_entry.kind = KIND_PAYLOAD;
        pay_entry.data = {96'd0, b};
        st_entry.last  = 1'b1;
        st_entry.kind  = KIND_STATUS;
        st_entry.data  = {5'd0, upd_length, upd_flags, upd_sequence, upd_type,
                          status, 8'd0};
    end

    always_comb begin
        if (in_fire && !s_axis_tlast) begin
            n_hdr_idx  = upd_hdr_idx;
            n_magic    = upd_magic;
            n_version  = upd_version;
            n_flags    = upd_flags;
            n_type     = upd_type;
            n_length   = upd_length;
            n_sequence = upd_sequence;
            n_checksum = upd_checksum;
            n_crc      = upd_crc;
            n_pay_cnt  = upd_pay_cnt;
        end else if (in_fire) begin
            n_hdr_idx  = '0;
            n_magic    = '0;
            n_version  = '0;
            n_flags    = '0;
            n_type     = '0;
            n_length   = '0;
            n_sequence = '0;
            n_checksum = '0;
            n_crc      = CRC_INIT;
            n_pay_cnt  = '0;
        end else begin
            n_hdr_idx  = r_hdr_idx;
            n_magic    = r_magic;
            n_version  = r_version;
            n_flags    = r_flags;
            n_type     = r_type;
            n_length   = r_length;
            n_sequence = r_sequence;
            n_checksum = r_checksum;
            n_crc      = r_crc;
            n_pay_cnt  = r_pay_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word  <= MAGIC_RST;
            r_max_version <= MAXV_RST;
            r_hdr_idx     <= '0;
            r_magic       <= '0;
            r_version     <= '0;
            r_flags       <= '0;
            r_type        <= '0;
            r_length      <= '0;
            r_sequence    <= '0;
            r_checksum    <= '0;
            r_crc         <= CRC_INIT;
            r_pay_cnt     <= '0;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_MAGIC_WORD:  r_magic_word  <= i_cfg_data;
                    CFG_MAX_VERSION: r_max_version <= i_cfg_data[7:0];
                    default:         r_magic_word  <= r_magic_word;
                endcase
            end
            r_hdr_idx  <= n_hdr_idx;
            r_magic    <= n_magic;
            r_version  <= n_version;
            r_flags    <= n_flags;
            r_type     <= n_type;
            r_length   <= n_length;
            r_sequence <= n_sequence;
            r_checksum <= n_checksum;
            r_crc      <= n_crc;
            r_pay_cnt  <= n_pay_cnt;
            r_wr_ptr   <= r_wr_ptr + Q_PTR_W'(push_pay) + Q_PTR_W'(push_st);
            r_rd_ptr   <= r_rd_ptr + Q_PTR_W'(out_fire);
            r_count    <= r_count + Q_CNT_W'(push_pay) + Q_CNT_W'(push_st)
                          - Q_CNT_W'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_pay) begin
            r_queue[r_wr_ptr] <= pay_entry;
        end
        if (push_st) begin
            r_queue[r_wr_ptr + Q_PTR_W'(push_pay)] <= st_entry;
        end
    end

    assign s_axis_tready = r_count <= Q_CNT_W'(Q_DEPTH - 2);
    assign m_axis_tvalid = r_count != '0;
    assign m_axis_tdata  = r_queue[r_rd_ptr].data;
    assign m_axis_tuser  = r_queue[r_rd_ptr].kind;
    assign m_axis_tlast  = r_queue[r_rd_ptr].last;

    `ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n, r_count > Q_CNT_W'(Q_DEPTH), "output queue overflow")
    `ASSERT_PROP(a_rearm_after_end, i_clk, i_rst_n, (in_fire && s_axis_tlast) |=> (r_hdr_idx == '0 && r_pay_cnt == '0 && r_crc == CRC_INIT), "parser did not rearm after end of buffer")
    `ASSERT_NEVER(a_count_in_range, i_clk, i_rst_n, r_pay_cnt > r_length, "payload count exceeds declared length")
    `ASSERT_PROP(a_status_is_last, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "status beat without last mark")

endmodule
